// ===== src/fat_pkg.sv =====
// Shared constants, types and codes for the flow affinity table.
`timescale 1ns / 1ps
package fat_pkg;

  localparam int unsigned SLOTS = 1024;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned OCC_W = IDX_W + 1;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned TGT_W = 8;
  localparam int unsigned OUTC_W = 3;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned TMO_W = 32;
  localparam int unsigned ENT_W = 1 + TIME_W + TGT_W + KEY_W;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [OCC_W-1:0] FULL_LEVEL = OCC_W'(SLOTS - 2);
  localparam logic [CNT_W-1:0] MAX_COUNT = 9'd256;
  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_SEED = 64'h9e3779b97f4a7c15;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 32'd120000;
  localparam logic [CNT_W-1:0] COUNT_RST = 9'd1;

  localparam logic CFG_TARGET_COUNT = 1'b0;
  localparam logic CFG_IDLE_TIMEOUT = 1'b1;

  localparam logic [OUTC_W-1:0] OUTC_HIT = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_NEW = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_REASSIGN = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_FULL = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_NO_TARGETS = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_CHECK, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3,
    ST_DIV, ST_WRITE, ST_DONE
  } state_t;

  typedef enum logic [1:0] {MUL_LL, MUL_LH, MUL_HL, MUL_SUM} mul_step_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic idx_inc;
    logic set_outcome;
    logic [OUTC_W-1:0] outcome;
    logic tgt_zero;
    logic wr_hit;
    logic mul_en;
    mul_step_t mul_step;
    logic div_en;
    logic wr_entry;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic count_zero;
    logic count_le1;
    logic ent_valid;
    logic key_match;
    logic expired;
    logic full;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/fat_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module fat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fat_ctrl.sv =====
// Sequencer for clearing, probing, target drawing and result hand-off.
`timescale 1ns / 1ps
module fat_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fat_pkg::sts_t sts,
  output fat_pkg::cmd_t cmd
);

  fat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fat_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fat_pkg::ST_CLEAR: if (sts.clr_last) state_next = fat_pkg::ST_IDLE;
      fat_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.count_zero ? fat_pkg::ST_DONE : fat_pkg::ST_LOOKUP;
        end
      end
      fat_pkg::ST_LOOKUP: state_next = fat_pkg::ST_CHECK;
      fat_pkg::ST_CHECK: begin
        priority if (!sts.ent_valid) begin
          if (sts.full) state_next = fat_pkg::ST_DONE;
          else if (sts.count_le1) state_next = fat_pkg::ST_WRITE;
          else state_next = fat_pkg::ST_MUL0;
        end else if (sts.key_match) begin
          if (!sts.expired) state_next = fat_pkg::ST_DONE;
          else if (sts.count_le1) state_next = fat_pkg::ST_WRITE;
          else state_next = fat_pkg::ST_MUL0;
        end else begin
          state_next = fat_pkg::ST_LOOKUP;
        end
      end
      fat_pkg::ST_MUL0: state_next = fat_pkg::ST_MUL1;
      fat_pkg::ST_MUL1: state_next = fat_pkg::ST_MUL2;
      fat_pkg::ST_MUL2: state_next = fat_pkg::ST_MUL3;
      fat_pkg::ST_MUL3: state_next = fat_pkg::ST_DIV;
      fat_pkg::ST_DIV: if (sts.div_last) state_next = fat_pkg::ST_WRITE;
      fat_pkg::ST_WRITE: state_next = fat_pkg::ST_DONE;
      fat_pkg::ST_DONE: if (sts.out_free) state_next = fat_pkg::ST_IDLE;
      default: state_next = fat_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_step = fat_pkg::MUL_LL;
    in_ready = 1'b0;
    unique case (state)
      fat_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      fat_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.set_outcome = 1'b1;
          cmd.outcome = fat_pkg::OUTC_NO_TARGETS;
          cmd.tgt_zero = 1'b1;
        end
      end
      fat_pkg::ST_LOOKUP: ;
      fat_pkg::ST_CHECK: begin
        priority if (!sts.ent_valid) begin
          cmd.set_outcome = 1'b1;
          cmd.tgt_zero = 1'b1;
          cmd.outcome = sts.full ? fat_pkg::OUTC_FULL : fat_pkg::OUTC_NEW;
        end else if (sts.key_match) begin
          cmd.set_outcome = 1'b1;
          if (sts.expired) begin
            cmd.tgt_zero = 1'b1;
            cmd.outcome = fat_pkg::OUTC_REASSIGN;
          end else begin
            cmd.outcome = fat_pkg::OUTC_HIT;
            cmd.wr_hit = 1'b1;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      fat_pkg::ST_MUL0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_step = fat_pkg::MUL_LL;
      end
      fat_pkg::ST_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_step = fat_pkg::MUL_LH;
      end
      fat_pkg::ST_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_step = fat_pkg::MUL_HL;
      end
      fat_pkg::ST_MUL3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_step = fat_pkg::MUL_SUM;
      end
      fat_pkg::ST_DIV: cmd.div_en = 1'b1;
      fat_pkg::ST_WRITE: cmd.wr_entry = 1'b1;
      fat_pkg::ST_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/fat_dp.sv =====
// Datapath: slot memory, probe index, LCG, remainder unit and result register.
`timescale 1ns / 1ps
module fat_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [fat_pkg::KEY_W-1:0]      in_key,
  input  logic [fat_pkg::TIME_W-1:0]     in_time,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [fat_pkg::TMO_W-1:0]      cfg_data,
  input  fat_pkg::cmd_t                  cmd,
  output fat_pkg::sts_t                  sts,
  input  logic                           res_ready,
  output logic                           res_valid,
  output logic [fat_pkg::TGT_W-1:0]      res_target,
  output logic [fat_pkg::OUTC_W-1:0]     res_outcome
);

  logic [fat_pkg::CNT_W-1:0] target_count;
  logic [fat_pkg::TMO_W-1:0] idle_timeout;
  logic [fat_pkg::CNT_W-1:0] count_eff;
  logic [fat_pkg::CNT_W-1:0] count;
  logic [fat_pkg::KEY_W-1:0] key;
  logic [fat_pkg::TIME_W-1:0] now;
  logic [fat_pkg::TMO_W-1:0] timeout;
  logic [fat_pkg::IDX_W-1:0] idx;
  logic [fat_pkg::IDX_W-1:0] clr_cnt;
  logic [fat_pkg::OCC_W-1:0] occ;
  logic [63:0] gen;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [4:0] div_cnt;
  logic [fat_pkg::CNT_W-1:0] rem;
  logic [fat_pkg::CNT_W:0] rem_sh;
  logic [fat_pkg::CNT_W-1:0] rem_next;
  logic [31:0] gen_hi;
  logic [fat_pkg::TGT_W-1:0] target;
  logic [fat_pkg::OUTC_W-1:0] outcome;

  logic ram_we;
  logic [fat_pkg::IDX_W-1:0] ram_waddr;
  logic [fat_pkg::ENT_W-1:0] ram_wdata;
  logic [fat_pkg::ENT_W-1:0] ent;
  logic ent_valid;
  logic [fat_pkg::TIME_W-1:0] ent_time;
  logic [fat_pkg::TGT_W-1:0] ent_target;
  logic [fat_pkg::KEY_W-1:0] ent_key;
  logic [fat_pkg::TIME_W-1:0] age;

  assign {ent_valid, ent_time, ent_target, ent_key} = ent;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      target_count <= fat_pkg::COUNT_RST;
      idle_timeout <= fat_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fat_pkg::CFG_TARGET_COUNT: target_count <= cfg_data[fat_pkg::CNT_W-1:0];
        fat_pkg::CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count_eff = (target_count > fat_pkg::MAX_COUNT) ? fat_pkg::MAX_COUNT : target_count;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= in_key;
      now <= in_time;
      count <= count_eff;
      timeout <= idle_timeout;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= in_key[fat_pkg::IDX_W-1:0];
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx;
    ram_wdata = {1'b1, now, target, key};
    priority if (cmd.clr_step) begin
      ram_we = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (cmd.wr_hit) begin
      ram_we = 1'b1;
      ram_wdata = {1'b1, now, ent_target, key};
    end else if (cmd.wr_entry) begin
      ram_we = 1'b1;
    end else begin
      ram_we = 1'b0;
    end
  end

  fat_ram #(
    .WIDTH(fat_pkg::ENT_W),
    .DEPTH(fat_pkg::SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.wr_entry && outcome == fat_pkg::OUTC_NEW) begin
      occ <= occ + 1'b1;
    end
  end

  // LCG step, 64x64 low half from three 32x32 products
  always_comb begin
    unique case (cmd.mul_step)
      fat_pkg::MUL_LL: begin
        mul_a = gen[31:0];
        mul_b = fat_pkg::LCG_MUL[31:0];
      end
      fat_pkg::MUL_LH: begin
        mul_a = gen[31:0];
        mul_b = fat_pkg::LCG_MUL[63:32];
      end
      fat_pkg::MUL_HL: begin
        mul_a = gen[63:32];
        mul_b = fat_pkg::LCG_MUL[31:0];
      end
      default: begin
        mul_a = gen[63:32];
        mul_b = fat_pkg::LCG_MUL[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
      unique case (cmd.mul_step)
        fat_pkg::MUL_LL: acc <= acc;
        fat_pkg::MUL_LH: acc <= prod;
        default: acc <= acc + {prod[31:0], 32'd0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= fat_pkg::LCG_SEED;
    end else if (cmd.mul_en && cmd.mul_step == fat_pkg::MUL_SUM) begin
      gen <= acc + {prod[31:0], 32'd0} + 64'd1;
    end
  end

  // restoring remainder, one quotient bit per cycle
  assign gen_hi = gen[63:32];
  assign rem_sh = {rem, gen_hi[5'd31 - div_cnt]};
  assign rem_next = (rem_sh >= {1'b0, count}) ? fat_pkg::CNT_W'(rem_sh - {1'b0, count})
                                              : rem_sh[fat_pkg::CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_en) begin
      rem <= rem_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.tgt_zero) begin
      target <= '0;
    end else if (cmd.wr_hit) begin
      target <= ent_target;
    end else if (cmd.div_en) begin
      target <= rem_next[fat_pkg::TGT_W-1:0];
    end else begin
      target <= target;
    end
    if (cmd.set_outcome) begin
      outcome <= cmd.outcome;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_target <= target;
      res_outcome <= outcome;
    end
  end

  assign age = now - ent_time;

  always_comb begin
    sts.clr_last = (clr_cnt == fat_pkg::IDX_W'(fat_pkg::SLOTS - 1));
    sts.count_zero = (count_eff == '0);
    sts.count_le1 = (count <= fat_pkg::CNT_W'(1));
    sts.ent_valid = ent_valid;
    sts.key_match = (ent_key == key);
    sts.expired = (now > ent_time) && (age > fat_pkg::TIME_W'(timeout));
    sts.full = (occ >= fat_pkg::FULL_LEVEL);
    sts.div_last = (div_cnt == 5'(fat_pkg::DIV_STEPS - 1));
    sts.out_free = !res_valid || res_ready;
  end

endmodule

// ===== src/flow_affinity_table.sv =====
// Top level of the flow affinity table.
//
// Slave stream: one beat per packet, tdata = {time_ms, flow_key}. Master
// stream: one beat per packet, tdata = {outcome, target}, in input order.
// Configuration: cfg_we with cfg_index 0 (target_count) or 1
// (idle_timeout_ms); write only while the block is idle.
// After reset the slot memory is cleared, one slot a cycle: s_tready stays
// low meanwhile. Registers return to target_count 1, timeout 120000.
// Steps per beat: accept, a memory read and a compare per slot probed,
// then on a target draw the LCG multiply on the shared 32x32 multiplier
// and the bit-serial remainder, then the slot write and the result load.
// One packet is in work at a time. A finished beat waits in the output
// register while the next packet is taken; a stalled master holds the
// sequencer at its result load until the register frees.
`timescale 1ns / 1ps
module flow_affinity_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // flow_key[63:0], time_ms[111:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // target[7:0], outcome[10:8], zero[15:11]
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  fat_pkg::cmd_t cmd;
  fat_pkg::sts_t sts;
  logic [fat_pkg::TGT_W-1:0] target;
  logic [fat_pkg::OUTC_W-1:0] outcome;

  fat_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  fat_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_key     (s_tdata[63:0]),
    .in_time    (s_tdata[111:64]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .res_ready  (m_tready),
    .res_valid  (m_tvalid),
    .res_target (target),
    .res_outcome(outcome)
  );

  assign m_tdata = {5'd0, outcome, target};

endmodule

// ===== verif/tb_flow_affinity_table.sv =====
// Testbench for the flow affinity table: directed and random packets checked against a local model.
`timescale 1ns / 1ps
module tb_flow_affinity_table;
  import fat_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    bit                typed;
    logic [TGT_W-1:0]  tgt;
    logic [OUTC_W-1:0] outc;
  } pkt_row_t;

  typedef struct {
    logic [TGT_W-1:0]  tgt;
    logic [OUTC_W-1:0] outc;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CFG_TARGET_COUNT;
  logic [31:0]  cfg_data = '0;

  always #5 clk = ~clk;

  flow_affinity_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the table
  bit                slot_used [SLOTS];
  logic [KEY_W-1:0]  slot_key [SLOTS];
  logic [TGT_W-1:0]  slot_tgt [SLOTS];
  logic [TIME_W-1:0] slot_seen [SLOTS];
  int unsigned       occupancy;
  logic [63:0]       lcg;
  logic [CNT_W-1:0]  target_count;
  logic [TMO_W-1:0]  idle_timeout;

  verdict_t          pending_q[$];
  logic [KEY_W-1:0]  known_keys[$];
  int                fails = 0;
  int                packets = 0;
  int                beats = 0;
  int                outc_seen [5];
  int                quiet_cycles = 0;
  bit                src_calm = 1'b0;
  bit                sink_calm = 1'b0;
  int                stall_left = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic logic [TGT_W-1:0] draw_target(int unsigned count);
    logic [31:0] hi;
    if (count <= 1) return '0;
    lcg = lcg * LCG_MUL + 64'd1;
    hi = lcg[63:32];
    return TGT_W'(hi % count);
  endfunction

  function automatic verdict_t assign_flow(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
    verdict_t v;
    int unsigned count, idx;
    count = (target_count > MAX_COUNT) ? 256 : int'(target_count);
    idx = key[IDX_W-1:0];
    v.tgt = '0;
    if (count == 0) begin
      v.outc = OUTC_NO_TARGETS;
      return v;
    end
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[idx]) begin
        if (occupancy + 2 >= SLOTS) begin
          v.outc = OUTC_FULL;
          return v;
        end
        slot_used[idx] = 1'b1;
        slot_key[idx] = key;
        slot_tgt[idx] = draw_target(count);
        slot_seen[idx] = now;
        occupancy++;
        known_keys.push_back(key);
        v.tgt = slot_tgt[idx];
        v.outc = OUTC_NEW;
        return v;
      end
      if (slot_key[idx] == key) begin
        v.outc = OUTC_HIT;
        if (now > slot_seen[idx] && (now - slot_seen[idx]) > TIME_W'(idle_timeout)) begin
          slot_tgt[idx] = draw_target(count);
          v.outc = OUTC_REASSIGN;
        end
        slot_seen[idx] = now;
        v.tgt = slot_tgt[idx];
        return v;
      end
      idx = (idx + 1) % SLOTS;
    end
    v.outc = OUTC_FULL;
    return v;
  endfunction

  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_flow(input pkt_row_t row);
    int g;
    verdict_t v;
    g = gap_len(src_calm);
    if (g > 0) begin
      s_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {row.stamp, row.key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v = assign_flow(row.key, row.stamp);
    if (row.typed) begin
      v.tgt = row.tgt;
      v.outc = row.outc;
    end
    pending_q.push_back(v);
    packets++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    if (idx == CFG_TARGET_COUNT) target_count = value[CNT_W-1:0];
    else idle_timeout = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic pkt_row_t random_flow(int new_pct);
    pkt_row_t row;
    int r;
    row.typed = 1'b0;
    row.tgt = '0;
    row.outc = '0;
    r = $urandom_range(0, 99);
    if (known_keys.size() == 0 || r < new_pct) begin
      row.key = {$urandom, $urandom};
    end else if (r < new_pct + 10) begin
      // same home slot as a known flow, different key
      row.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      row.key[KEY_W-1:IDX_W] = {$urandom, $urandom};
    end else begin
      row.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(0, 500);
    else if (r < 82) clock_ms = clock_ms + TIME_W'(idle_timeout) + $urandom_range(0, 3);
    else if (r < 88) clock_ms = clock_ms - $urandom_range(1, 1000);
    else if (r < 94) clock_ms = {$urandom, $urandom};
    else clock_ms = clock_ms + {$urandom_range(0, 3), $urandom};
    row.stamp = clock_ms;
    return row;
  endfunction

  task automatic random_phase(input int items, input int new_pct);
    for (int i = 0; i < items; i++) begin
      if (i % 150 == 0) begin
        src_calm = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
      end
      send_flow(random_flow(new_pct));
    end
  endtask

  // sink side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      stall_left <= gap_len(sink_calm);
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      beats++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, m_tdata);
        fails++;
      end else begin
        v = pending_q.pop_front();
        if (m_tdata[7:0] !== v.tgt) begin
          $display("%0t: target expected %0d got %0d", $time, v.tgt, m_tdata[7:0]);
          fails++;
        end
        if (m_tdata[10:8] !== v.outc) begin
          $display("%0t: outcome expected %0d got %0d", $time, v.outc, m_tdata[10:8]);
          fails++;
        end
        if (m_tdata[10:8] < 5) outc_seen[m_tdata[10:8]]++;
      end
    end
  end

  pkt_row_t directed [] = '{
    '{64'd0, 48'd0, 1, 8'd0, OUTC_NEW},
    '{64'd0, 48'd0, 1, 8'd0, OUTC_HIT},
    '{64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 8'd0, OUTC_NEW},
    '{64'd0, 48'd120001, 1, 8'd0, OUTC_REASSIGN},
    '{64'd0, 48'd5, 1, 8'd0, OUTC_HIT},
    '{64'd1024, 48'd7, 1, 8'd0, OUTC_NEW},
    '{64'd2048, 48'd9, 1, 8'd0, OUTC_NEW},
    '{64'hFFFF_FFFF_FFFF_FFFF, 48'd0, 1, 8'd0, OUTC_HIT},
    '{64'd0, 48'd120005, 1, 8'd0, OUTC_HIT},
    '{64'd2048, 48'd120010, 1, 8'd0, OUTC_REASSIGN},
    '{64'd2048, 48'hFFFF_FFFF_FFFF, 1, 8'd0, OUTC_REASSIGN},
    '{64'h8000_0000_0000_03FF, 48'd1, 1, 8'd0, OUTC_NEW}
  };

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    occupancy = 0;
    lcg = LCG_SEED;
    target_count = COUNT_RST;
    idle_timeout = TIMEOUT_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_calm = 1'b1;
    foreach (directed[i]) send_flow(directed[i]);
    settle();

    write_reg(CFG_TARGET_COUNT, 32'hFFFF_FF00 | 32'd256);
    write_reg(CFG_IDLE_TIMEOUT, 32'd0);
    random_phase(350, 30);
    settle();

    write_reg(CFG_TARGET_COUNT, 32'd7);
    write_reg(CFG_IDLE_TIMEOUT, 32'hFFFF_FFFF);
    random_phase(250, 30);
    settle();

    write_reg(CFG_TARGET_COUNT, 32'd2);
    write_reg(CFG_IDLE_TIMEOUT, 32'd1000);
    random_phase(150, 30);
    settle();

    write_reg(CFG_TARGET_COUNT, 32'h0000_0200);
    random_phase(30, 30);
    settle();

    // fill towards the refusal level with an over-range count
    write_reg(CFG_TARGET_COUNT, 32'd511);
    write_reg(CFG_IDLE_TIMEOUT, TIMEOUT_RST);
    while (occupancy + 2 < SLOTS) begin
      src_calm = ($urandom_range(0, 3) == 0);
      send_flow(random_flow(85));
    end
    random_phase(300, 50);
    settle();

    $display("%0d packets sent, %0d beats returned, table holds %0d flows", packets, beats,
             occupancy);
    $display("hit %0d, new %0d, reassigned %0d, full %0d, no targets %0d", outc_seen[0],
             outc_seen[1], outc_seen[2], outc_seen[3], outc_seen[4]);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fat_pkg.sv
src/fat_ram.sv
src/fat_ctrl.sv
src/fat_dp.sv
src/flow_affinity_table.sv
verif/tb_flow_affinity_table.sv
